### sv/gsec_pkg.sv
package gsec_pkg;

  localparam int MaxVertices = 16;
  localparam int MaxDegree   = 8;
  localparam int MaxEdges    = 32;
  localparam int StackDepth  = MaxEdges + 1;

  localparam int VertW  = 4;  // vertex index
  localparam int DegW   = 3;  // entry index inside a row
  localparam int LenW   = 4;  // row length, 0 to MaxDegree
  localparam int EdgeW  = 6;  // edge count, 0 to MaxEdges
  localparam int SpW    = 6;  // stack pointers, 0 to StackDepth
  localparam int CntW   = 5;  // vertex count, 1 to MaxVertices
  localparam int AddrW  = VertW + DegW;
  localparam int EntryW = VertW + 1;  // used mark on top of the neighbor

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_RUN    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_LEN_A,
    CMD_LEN_B,
    CMD_APPEND_A,
    CMD_APPEND_B,
    CMD_DEL_SETUP_A,
    CMD_DEL_SETUP_B,
    CMD_RD_I,
    CMD_INC_I,
    CMD_RD_NEXT,
    CMD_WR_SHIFT,
    CMD_SHRINK,
    CMD_ET_DEC,
    CMD_SET_NB,
    CMD_EU_STEP,
    CMD_RUN_INIT,
    CMD_RD_TOP,
    CMD_SET_U,
    CMD_TAKE,
    CMD_MARK_SETUP,
    CMD_MARK,
    CMD_PUSH,
    CMD_POP,
    CMD_RD_CS,
    CMD_EMIT,
    CMD_EMIT_CIR
  } dp_cmd_e;

  typedef struct packed {
    dp_cmd_e cmd;
    status_e st;
    logic    qry;
  } dp_ctrl_t;

  typedef struct packed {
    op_e  op;
    logic a_ok;
    logic b_ok;
    logic ins_ok;
    logic i_end;
    logic sh_more;
    logic match;
    logic rd_used;
    logic mark_hit;
    logic k_end;
    logic sp_empty;
    logic sp_full;
    logic cp_empty;
    logic out_free;
  } dp_stat_t;

endpackage

### sv/graph_store_euler_circuit_top.sv
// channel   | dir | handshake               | payload
// s_axis    | in  | s_tvalid_i / s_tready_o | tdata: op, vertex_a, vertex_b
// m_axis    | out | m_tvalid_o / m_tready_i | tdata: vertex, degree, flags, status; tlast
// apb       | in  | psel/penable/pready     | vertex_count at byte address 0
//
// one transaction at a time; a circuit run walks edges and pops vertices, then emits
// the collected circuit vertices
// reset clears row lengths, edge count and stacks; no clearing pass is needed
// a stalled result sits in the output register; the next transaction is taken
// once the controller is back in idle
module graph_store_euler_circuit_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [15:0] s_tdata_i,   // [1:0] op, [5:2] vertex_a, [9:6] vertex_b, rest zero
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [15:0] m_tdata_o,   // [3:0] vertex, [7:4] degree, [8] is_neighbor,
                                   // [9] is_eulerian, [11:10] status, rest zero
  output logic        m_tlast_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import gsec_pkg::*;

  logic [CntW-1:0]  vcount_q;
  logic [CntW-1:0]  wr_val;
  dp_ctrl_t         ctrl;
  dp_stat_t         stat;
  logic [VertW-1:0] out_vertex;
  logic [LenW-1:0]  out_degree;
  logic             out_nb, out_eu;
  logic [1:0]       out_status;

  // config write with clamp to 1..MaxVertices; only one register, so any
  // word address inside the window lands on it
  assign pready = 1'b1;
  assign prdata = {{(32 - CntW){1'b0}}, vcount_q};

  always_comb begin
    wr_val = pwdata[CntW-1:0];
    if (wr_val == '0) begin
      wr_val = CntW'(1);
    end else if (wr_val > CntW'(MaxVertices)) begin
      wr_val = CntW'(MaxVertices);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= CntW'(MaxVertices);
    end else if (psel && penable && pwrite && pready && paddr[1:0] == paddr) begin
      vcount_q <= wr_val;
    end
  end

  gsec_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_tvalid_i),
    .in_ready_o (s_tready_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  gsec_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .vcount_i     (vcount_q),
    .in_op_i      (s_tdata_i[1:0]),
    .in_a_i       (s_tdata_i[5:2]),
    .in_b_i       (s_tdata_i[9:6]),
    .ctrl_i       (ctrl),
    .stat_o       (stat),
    .out_valid_o  (m_tvalid_o),
    .out_ready_i  (m_tready_i),
    .out_vertex_o (out_vertex),
    .out_last_o   (m_tlast_o),
    .out_degree_o (out_degree),
    .out_nb_o     (out_nb),
    .out_eu_o     (out_eu),
    .out_status_o (out_status)
  );

  assign m_tdata_o = {4'd0, out_status, out_eu, out_nb, out_degree, out_vertex};

endmodule

### sv/gsec_datapath.sv
module gsec_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [gsec_pkg::CntW-1:0]   vcount_i,
  input  logic [1:0]                  in_op_i,
  input  logic [gsec_pkg::VertW-1:0]  in_a_i,
  input  logic [gsec_pkg::VertW-1:0]  in_b_i,
  input  gsec_pkg::dp_ctrl_t          ctrl_i,
  output gsec_pkg::dp_stat_t          stat_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [gsec_pkg::VertW-1:0]  out_vertex_o,
  output logic                        out_last_o,
  output logic [gsec_pkg::LenW-1:0]   out_degree_o,
  output logic                        out_nb_o,
  output logic                        out_eu_o,
  output logic [1:0]                  out_status_o
);
  import gsec_pkg::*;

  // neighbor rows with used marks, {used, neighbor}
  logic [EntryW-1:0] row_mem [MaxVertices*MaxDegree];
  logic [VertW-1:0]  work_mem [StackDepth];
  logic [VertW-1:0]  circ_mem [StackDepth];

  logic [LenW-1:0]   rowlen_q [MaxVertices];
  logic [EdgeW-1:0]  edge_q;
  logic [SpW-1:0]    sp_q, cp_q;
  logic              out_valid_q;

  op_e               op_q;
  logic [VertW-1:0]  a_q, b_q, r_q, v_q, w_q;
  logic [LenW-1:0]   n_q, m_q, i_q;
  logic [CntW-1:0]   k_q;
  logic              nb_q, eu_q;
  logic [EntryW-1:0] rd_q;
  logic [VertW-1:0]  ws_rd_q, cs_rd_q;

  logic [VertW-1:0]  rl_addr;
  logic [LenW-1:0]   rl_rd;
  logic [AddrW-1:0]  mem_raddr, mem_waddr;
  logic [EntryW-1:0] mem_wdata;
  logic              mem_we;
  logic [DegW-1:0]   i_idx;

  assign i_idx = i_q[DegW-1:0];
  assign rl_rd = rowlen_q[rl_addr];

  always_comb begin
    case (ctrl_i.cmd) inside
      CMD_LEN_B, CMD_APPEND_B, CMD_DEL_SETUP_B: rl_addr = b_q;
      CMD_SHRINK:     rl_addr = r_q;
      CMD_EU_STEP:    rl_addr = k_q[VertW-1:0];
      CMD_SET_U:      rl_addr = ws_rd_q;
      CMD_MARK_SETUP: rl_addr = w_q;
      default:        rl_addr = a_q;
    endcase
  end

  always_comb begin
    mem_raddr = (ctrl_i.cmd == CMD_RD_NEXT) ? {r_q, i_idx + DegW'(1)} : {r_q, i_idx};
    mem_we    = 1'b0;
    mem_waddr = {r_q, i_idx};
    mem_wdata = rd_q;
    case (ctrl_i.cmd)
      CMD_APPEND_A: begin
        mem_we    = 1'b1;
        mem_waddr = {a_q, rl_rd[DegW-1:0]};
        mem_wdata = {1'b0, b_q};
      end
      CMD_APPEND_B: begin
        mem_we    = 1'b1;
        mem_waddr = {b_q, rl_rd[DegW-1:0]};
        mem_wdata = {1'b0, a_q};
      end
      CMD_TAKE: begin
        mem_we    = 1'b1;
        mem_wdata = {1'b1, rd_q[VertW-1:0]};
      end
      CMD_MARK: begin
        mem_we    = 1'b1;
        mem_wdata = {1'b1, v_q};
      end
      CMD_WR_SHIFT: mem_we = 1'b1;
      default: ;
    endcase
  end

  // status toward the controller
  always_comb begin
    stat_o.op       = op_q;
    stat_o.a_ok     = {1'b0, a_q} < vcount_i;
    stat_o.b_ok     = {1'b0, b_q} < vcount_i;
    stat_o.ins_ok   = (edge_q < EdgeW'(MaxEdges)) &&
                      ((a_q == b_q) ? (n_q <= LenW'(MaxDegree - 2))
                                    : (n_q < LenW'(MaxDegree) && m_q < LenW'(MaxDegree)));
    stat_o.i_end    = i_q >= n_q;
    stat_o.sh_more  = (i_q + LenW'(1)) < n_q;
    stat_o.match    = rd_q[VertW-1:0] == v_q;
    stat_o.rd_used  = rd_q[VertW];
    stat_o.mark_hit = (rd_q[VertW-1:0] == v_q) && !rd_q[VertW];
    stat_o.k_end    = k_q >= vcount_i;
    stat_o.sp_empty = sp_q == '0;
    stat_o.sp_full  = sp_q >= SpW'(StackDepth);
    stat_o.cp_empty = cp_q == '0;
    stat_o.out_free = !out_valid_q || out_ready_i;
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      row_mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= row_mem[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmd == CMD_RUN_INIT) begin
      work_mem[0] <= a_q;
    end else if (ctrl_i.cmd == CMD_PUSH) begin
      work_mem[sp_q] <= w_q;
    end
    if (ctrl_i.cmd == CMD_RD_TOP) begin
      ws_rd_q <= work_mem[sp_q - SpW'(1)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmd == CMD_POP && cp_q < SpW'(StackDepth)) begin
      circ_mem[cp_q] <= r_q;
    end
    if (ctrl_i.cmd == CMD_RD_CS) begin
      cs_rd_q <= circ_mem[cp_q - SpW'(1)];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int v = 0; v < MaxVertices; v++) begin
        rowlen_q[v] <= '0;
      end
      edge_q      <= '0;
      sp_q        <= '0;
      cp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      case (ctrl_i.cmd)
        CMD_APPEND_A: rowlen_q[rl_addr] <= rl_rd + LenW'(1);
        CMD_APPEND_B: begin
          rowlen_q[rl_addr] <= rl_rd + LenW'(1);
          edge_q            <= edge_q + EdgeW'(1);
        end
        CMD_SHRINK:   rowlen_q[rl_addr] <= rl_rd - LenW'(1);
        CMD_ET_DEC: begin
          if (edge_q != '0) edge_q <= edge_q - EdgeW'(1);
        end
        CMD_RUN_INIT: begin
          sp_q <= SpW'(1);
          cp_q <= '0;
        end
        CMD_PUSH: sp_q <= sp_q + SpW'(1);
        CMD_POP: begin
          sp_q <= sp_q - SpW'(1);
          if (cp_q < SpW'(StackDepth)) cp_q <= cp_q + SpW'(1);
        end
        CMD_RD_CS: cp_q <= cp_q - SpW'(1);
        default: ;
      endcase
      if (ctrl_i.cmd == CMD_EMIT || ctrl_i.cmd == CMD_EMIT_CIR) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working registers and result payload
  always_ff @(posedge clk_i) begin
    case (ctrl_i.cmd)
      CMD_LOAD: begin
        op_q <= op_e'(in_op_i);
        a_q  <= in_a_i;
        b_q  <= in_b_i;
        nb_q <= 1'b0;
        eu_q <= 1'b1;
        k_q  <= '0;
      end
      CMD_LEN_A: n_q <= rl_rd;
      CMD_LEN_B: m_q <= rl_rd;
      CMD_DEL_SETUP_A: begin
        r_q <= a_q;
        v_q <= b_q;
        n_q <= rl_rd;
        i_q <= '0;
      end
      CMD_DEL_SETUP_B: begin
        r_q <= b_q;
        v_q <= a_q;
        n_q <= rl_rd;
        i_q <= '0;
      end
      CMD_INC_I, CMD_WR_SHIFT: i_q <= i_q + LenW'(1);
      CMD_SET_NB: nb_q <= 1'b1;
      CMD_EU_STEP: begin
        if (rl_rd == '0 || rl_rd[0]) eu_q <= 1'b0;
        k_q <= k_q + CntW'(1);
      end
      CMD_SET_U: begin
        r_q <= ws_rd_q;
        n_q <= rl_rd;
        i_q <= '0;
      end
      CMD_TAKE: w_q <= rd_q[VertW-1:0];
      CMD_MARK_SETUP: begin
        r_q <= w_q;
        v_q <= r_q;
        n_q <= rl_rd;
        i_q <= '0;
      end
      CMD_EMIT: begin
        out_vertex_o <= '0;
        out_last_o   <= 1'b1;
        out_degree_o <= ctrl_i.qry ? n_q : '0;
        out_nb_o     <= ctrl_i.qry & nb_q;
        out_eu_o     <= ctrl_i.qry & eu_q;
        out_status_o <= ctrl_i.st;
      end
      CMD_EMIT_CIR: begin
        out_vertex_o <= cs_rd_q;
        out_last_o   <= cp_q == '0;
        out_degree_o <= '0;
        out_nb_o     <= 1'b0;
        out_eu_o     <= 1'b0;
        out_status_o <= ST_OK;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_edge_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    edge_q <= EdgeW'(MaxEdges))
    else $error("edge count above store size");
  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SpW'(StackDepth))
    else $error("work stack overrun");
  a_cp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cp_q <= SpW'(StackDepth))
    else $error("circuit stack overrun");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.cmd == CMD_EMIT || ctrl_i.cmd == CMD_EMIT_CIR) |-> stat_o.out_free)
    else $error("result loaded over a pending one");
`endif

endmodule

### sv/gsec_ctrl.sv
module gsec_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  gsec_pkg::dp_stat_t stat_i,
  output gsec_pkg::dp_ctrl_t ctrl_o
);
  import gsec_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_INS_LB, S_INS_CHK, S_INS_APB,
    S_SCAN_RD, S_SCAN_CMP, S_SH_RD, S_SH_WR, S_DEL_B, S_REM_DONE,
    S_EU_LOOP, S_RUN_LOOP, S_RUN_TOP, S_RUN_FIND, S_RUN_FCMP,
    S_RUN_MSET, S_RUN_MRD, S_RUN_MCMP, S_RUN_PUSH,
    S_OUT_RD, S_OUT_EMIT, S_EMIT
  } state_e;

  state_e  state_q, state_d;
  status_e st_q, st_d;
  logic    qry_q, qry_d;
  logic    phase_q, phase_d;

  assign in_ready_o = state_q == S_IDLE;

  always_comb begin
    state_d    = state_q;
    st_d       = st_q;
    qry_d      = qry_q;
    phase_d    = phase_q;
    ctrl_o.cmd = CMD_NONE;
    ctrl_o.st  = st_q;
    ctrl_o.qry = qry_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.cmd = CMD_LOAD;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        qry_d   = 1'b0;
        phase_d = 1'b0;
        st_d    = ST_RANGE;
        if (stat_i.op == OP_RUN) begin
          if (!stat_i.a_ok) begin
            state_d = S_EMIT;
          end else begin
            ctrl_o.cmd = CMD_RUN_INIT;
            state_d    = S_RUN_LOOP;
          end
        end else if (!stat_i.a_ok || !stat_i.b_ok) begin
          state_d = S_EMIT;
        end else if (stat_i.op == OP_INSERT) begin
          ctrl_o.cmd = CMD_LEN_A;
          state_d    = S_INS_LB;
        end else begin
          ctrl_o.cmd = CMD_DEL_SETUP_A;
          qry_d      = stat_i.op == OP_QUERY;
          state_d    = S_SCAN_RD;
        end
      end
      S_INS_LB: begin
        ctrl_o.cmd = CMD_LEN_B;
        state_d    = S_INS_CHK;
      end
      S_INS_CHK: begin
        if (stat_i.ins_ok) begin
          ctrl_o.cmd = CMD_APPEND_A;
          state_d    = S_INS_APB;
        end else begin
          st_d    = ST_FULL;
          state_d = S_EMIT;
        end
      end
      S_INS_APB: begin
        ctrl_o.cmd = CMD_APPEND_B;
        st_d       = ST_OK;
        state_d    = S_EMIT;
      end
      S_SCAN_RD: begin
        if (stat_i.i_end) begin
          if (qry_q) begin
            state_d = S_EU_LOOP;
          end else if (phase_q) begin
            state_d = S_REM_DONE;
          end else begin
            st_d    = ST_MISSING;
            state_d = S_EMIT;
          end
        end else begin
          ctrl_o.cmd = CMD_RD_I;
          state_d    = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (stat_i.match) begin
          if (qry_q) begin
            ctrl_o.cmd = CMD_SET_NB;
            state_d    = S_EU_LOOP;
          end else begin
            state_d = S_SH_RD;
          end
        end else begin
          ctrl_o.cmd = CMD_INC_I;
          state_d    = S_SCAN_RD;
        end
      end
      S_SH_RD: begin
        if (stat_i.sh_more) begin
          ctrl_o.cmd = CMD_RD_NEXT;
          state_d    = S_SH_WR;
        end else begin
          ctrl_o.cmd = CMD_SHRINK;
          if (phase_q) begin
            state_d = S_REM_DONE;
          end else begin
            phase_d = 1'b1;
            state_d = S_DEL_B;
          end
        end
      end
      S_SH_WR: begin
        ctrl_o.cmd = CMD_WR_SHIFT;
        state_d    = S_SH_RD;
      end
      S_DEL_B: begin
        ctrl_o.cmd = CMD_DEL_SETUP_B;
        state_d    = S_SCAN_RD;
      end
      S_REM_DONE: begin
        ctrl_o.cmd = CMD_ET_DEC;
        st_d       = ST_OK;
        state_d    = S_EMIT;
      end
      S_EU_LOOP: begin
        if (stat_i.k_end) begin
          st_d    = ST_OK;
          state_d = S_EMIT;
        end else begin
          ctrl_o.cmd = CMD_EU_STEP;
        end
      end
      S_RUN_LOOP: begin
        if (stat_i.sp_empty) begin
          state_d = S_OUT_RD;
        end else begin
          ctrl_o.cmd = CMD_RD_TOP;
          state_d    = S_RUN_TOP;
        end
      end
      S_RUN_TOP: begin
        ctrl_o.cmd = CMD_SET_U;
        state_d    = S_RUN_FIND;
      end
      S_RUN_FIND: begin
        if (stat_i.sp_full || stat_i.i_end) begin
          ctrl_o.cmd = CMD_POP;
          state_d    = S_RUN_LOOP;
        end else begin
          ctrl_o.cmd = CMD_RD_I;
          state_d    = S_RUN_FCMP;
        end
      end
      S_RUN_FCMP: begin
        if (!stat_i.rd_used) begin
          ctrl_o.cmd = CMD_TAKE;
          state_d    = S_RUN_MSET;
        end else begin
          ctrl_o.cmd = CMD_INC_I;
          state_d    = S_RUN_FIND;
        end
      end
      S_RUN_MSET: begin
        ctrl_o.cmd = CMD_MARK_SETUP;
        state_d    = S_RUN_MRD;
      end
      S_RUN_MRD: begin
        if (stat_i.i_end) begin
          state_d = S_RUN_PUSH;
        end else begin
          ctrl_o.cmd = CMD_RD_I;
          state_d    = S_RUN_MCMP;
        end
      end
      S_RUN_MCMP: begin
        if (stat_i.mark_hit) begin
          ctrl_o.cmd = CMD_MARK;
          state_d    = S_RUN_PUSH;
        end else begin
          ctrl_o.cmd = CMD_INC_I;
          state_d    = S_RUN_MRD;
        end
      end
      S_RUN_PUSH: begin
        ctrl_o.cmd = CMD_PUSH;
        state_d    = S_RUN_LOOP;
      end
      S_OUT_RD: begin
        if (stat_i.cp_empty) begin
          state_d = S_IDLE;
        end else begin
          ctrl_o.cmd = CMD_RD_CS;
          state_d    = S_OUT_EMIT;
        end
      end
      S_OUT_EMIT: begin
        if (stat_i.out_free) begin
          ctrl_o.cmd = CMD_EMIT_CIR;
          state_d    = stat_i.cp_empty ? S_IDLE : S_OUT_RD;
        end
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          ctrl_o.cmd = CMD_EMIT;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= ST_OK;
      qry_q   <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
      qry_q   <= qry_d;
      phase_q <= phase_d;
    end
  end

`ifndef SYNTHESIS
  a_idle_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ready_o && in_valid_i) |=> state_q == S_DECODE)
    else $error("accepted transaction not decoded");
  a_emit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_o.cmd == CMD_EMIT) |=> state_q == S_IDLE)
    else $error("single result not followed by idle");
  a_phase_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DEL_B) |-> !qry_q)
    else $error("second deletion outside removal");
`endif

endmodule
